### src/tbcp_pkg.sv
// Package with types, constants and lookup functions of the tagged block container parser.
`timescale 1ns / 1ps

package tbcp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MAGIC,
        PH_VER,
        PH_COUNT,
        PH_TAG,
        PH_SIZE,
        PH_DATA,
        PH_DONE
    } phase_t;

    localparam logic [2:0] ST_PARSING     = 3'd0;
    localparam logic [2:0] ST_OK          = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_STRUCTURE   = 3'd4;

    localparam logic [3:0] KIND_SKIP = 4'd8;

    localparam logic [2:0] MAGIC_LEN = 3'd7;

    localparam logic [7:0] TAG_CHAR_LO = 8'h30;
    localparam logic [7:0] TAG_CHAR_HI = 8'h5A;

    localparam logic [15:0] TAG_VERTICES   = 16'h4156;
    localparam logic [15:0] TAG_NORMALS    = 16'h414e;
    localparam logic [15:0] TAG_COLORS     = 16'h4143;
    localparam logic [15:0] TAG_SEC_COLORS = 16'h3243;
    localparam logic [15:0] TAG_TEXCOORDS  = 16'h4354;
    localparam logic [15:0] TAG_INDICES    = 16'h4149;
    localparam logic [15:0] TAG_SHORT_IDX  = 16'h3249;
    localparam logic [15:0] TAG_TEX_NAME   = 16'h4654;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h43;
            3'd1:    val = 8'h59;
            3'd2:    val = 8'h42;
            3'd3:    val = 8'h4F;
            3'd4:    val = 8'h52;
            3'd5:    val = 8'h55;
            3'd6:    val = 8'h53;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic [3:0] tag_kind(input logic [15:0] tag);
        logic [3:0] kind;
        case (tag)
            TAG_VERTICES:   kind = 4'd0;
            TAG_NORMALS:    kind = 4'd1;
            TAG_COLORS:     kind = 4'd2;
            TAG_SEC_COLORS: kind = 4'd3;
            TAG_TEXCOORDS:  kind = 4'd4;
            TAG_INDICES:    kind = 4'd5;
            TAG_SHORT_IDX:  kind = 4'd6;
            TAG_TEX_NAME:   kind = 4'd7;
            default:        kind = KIND_SKIP;
        endcase
        return kind;
    endfunction

    function automatic logic tag_char_ok(input logic [7:0] c);
        return c inside {[TAG_CHAR_LO:TAG_CHAR_HI]};
    endfunction

endpackage

### src/tagged_block_container_parser.sv
// Top level of the tagged block container parser: byte stream in, payload bytes with kind out.
`timescale 1ns / 1ps

// The parser takes one container byte per transfer and returns exactly one result transfer
// for each, valid in the cycle after the byte is taken. Throughput is one byte per clock:
// the header, count, tag and size fields are assembled by a single pass of narrow logic
// between the parser state registers and the result register, so the only thing that slows
// the input is back-pressure on the result side: while a result waits and m_tready is low,
// s_tready is low in the same cycle. Set s_tuser on the first byte of a container to restart
// parsing. max_version is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, as the block does not enforce this. max_version resets to 1.
module tagged_block_container_parser
    import tbcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] payload_byte
    output logic        m_tlast,   // block_last
    output logic [6:0]  m_tuser    // [0] payload_valid, [3:1] block_kind, [6:4] status
);

    logic [15:0] max_version_reg;

    phase_t      phase_reg,        phase_next,        phase_eff;
    logic [2:0]  fbi_reg,          fbi_next,          fbi_eff;
    logic [15:0] version_reg,      version_next,      version_eff;
    logic [15:0] blocks_left_reg,  blocks_left_next,  blocks_left_eff;
    logic [15:0] current_tag_reg,  current_tag_next,  current_tag_eff;
    logic [31:0] bytes_left_reg,   bytes_left_next,   bytes_left_eff;
    logic [3:0]  current_kind_reg, current_kind_next, current_kind_eff;
    logic [2:0]  final_status_reg, final_status_next, final_status_eff;

    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg,  m_tdata_next;
    logic        m_tlast_reg,  m_tlast_next;
    logic [6:0]  m_tuser_reg,  m_tuser_next;

    logic        in_xfer;
    logic [7:0]  in_byte;
    logic [15:0] byte_lo_hi;
    logic [31:0] size_acc;
    logic [31:0] bytes_dec;
    logic [15:0] blocks_dec;
    logic [3:0]  lookup_kind;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign in_byte  = s_tdata;

    assign phase_eff        = s_tuser ? PH_MAGIC : phase_reg;
    assign fbi_eff          = s_tuser ? 3'd0     : fbi_reg;
    assign version_eff      = s_tuser ? 16'd0    : version_reg;
    assign blocks_left_eff  = s_tuser ? 16'd0    : blocks_left_reg;
    assign current_tag_eff  = s_tuser ? 16'd0    : current_tag_reg;
    assign bytes_left_eff   = s_tuser ? 32'd0    : bytes_left_reg;
    assign current_kind_eff = s_tuser ? 4'd0     : current_kind_reg;
    assign final_status_eff = s_tuser ? 3'd0     : final_status_reg;

    assign byte_lo_hi  = fbi_eff[0] ? {in_byte, 8'h00} : {8'h00, in_byte};
    assign size_acc    = bytes_left_eff | ({24'h0, in_byte} << {fbi_eff[1:0], 3'b000});
    assign bytes_dec   = bytes_left_eff - 32'd1;
    assign blocks_dec  = blocks_left_eff - 16'd1;
    assign lookup_kind = tag_kind(current_tag_eff | byte_lo_hi);

    always_comb begin : next_state
        phase_next        = phase_eff;
        fbi_next          = fbi_eff;
        version_next      = version_eff;
        blocks_left_next  = blocks_left_eff;
        current_tag_next  = current_tag_eff;
        bytes_left_next   = bytes_left_eff;
        current_kind_next = current_kind_eff;
        final_status_next = final_status_eff;
        case (phase_eff)
            PH_MAGIC: begin
                if (in_byte != magic_byte(fbi_eff)) begin
                    final_status_next = ST_BAD_HEADER;
                    phase_next        = PH_DONE;
                end else if (fbi_eff + 3'd1 == MAGIC_LEN) begin
                    fbi_next   = 3'd0;
                    phase_next = PH_VER;
                end else begin
                    fbi_next = fbi_eff + 3'd1;
                end
            end
            PH_VER: begin
                version_next = version_eff | byte_lo_hi;
                if (fbi_eff[0]) begin
                    fbi_next = 3'd0;
                    if (version_next > max_version_reg) begin
                        final_status_next = ST_UNSUPPORTED;
                        phase_next        = PH_DONE;
                    end else begin
                        phase_next = PH_COUNT;
                    end
                end else begin
                    fbi_next = fbi_eff + 3'd1;
                end
            end
            PH_COUNT: begin
                blocks_left_next = blocks_left_eff | byte_lo_hi;
                if (fbi_eff[0]) begin
                    fbi_next = 3'd0;
                    if (blocks_left_next == 16'd0) begin
                        final_status_next = ST_OK;
                        phase_next        = PH_DONE;
                    end else begin
                        phase_next       = PH_TAG;
                        current_tag_next = 16'd0;
                    end
                end else begin
                    fbi_next = fbi_eff + 3'd1;
                end
            end
            PH_TAG: begin
                current_tag_next = current_tag_eff | byte_lo_hi;
                if (fbi_eff[0]) begin
                    fbi_next          = 3'd0;
                    current_kind_next = lookup_kind;
                    if (lookup_kind == KIND_SKIP &&
                        !(tag_char_ok(current_tag_next[7:0]) &&
                          tag_char_ok(current_tag_next[15:8]))) begin
                        final_status_next = ST_STRUCTURE;
                        phase_next        = PH_DONE;
                    end else begin
                        phase_next      = PH_SIZE;
                        bytes_left_next = 32'd0;
                    end
                end else begin
                    fbi_next = fbi_eff + 3'd1;
                end
            end
            PH_SIZE: begin
                bytes_left_next = size_acc;
                if (fbi_eff[1:0] == 2'd3) begin
                    fbi_next = 3'd0;
                    if (size_acc == 32'd0) begin
                        blocks_left_next = blocks_dec;
                        if (blocks_dec == 16'd0) begin
                            final_status_next = ST_OK;
                            phase_next        = PH_DONE;
                        end else begin
                            phase_next       = PH_TAG;
                            current_tag_next = 16'd0;
                        end
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    fbi_next = fbi_eff + 3'd1;
                end
            end
            PH_DATA: begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == 32'd0) begin
                    blocks_left_next = blocks_dec;
                    if (blocks_dec == 16'd0) begin
                        final_status_next = ST_OK;
                        phase_next        = PH_DONE;
                    end else begin
                        phase_next       = PH_TAG;
                        current_tag_next = 16'd0;
                        fbi_next         = 3'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin : result_fields
        logic       pvalid;
        logic [2:0] stat;
        pvalid       = (phase_eff == PH_DATA) && (current_kind_eff < KIND_SKIP);
        stat         = (phase_next == PH_DONE) ? final_status_next : ST_PARSING;
        m_tdata_next = pvalid ? in_byte : 8'h00;
        m_tlast_next = pvalid && (bytes_dec == 32'd0);
        m_tuser_next = {stat, (pvalid ? current_kind_eff[2:0] : 3'd0), pvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_version_reg  <= 16'd1;
            phase_reg        <= PH_IDLE;
            fbi_reg          <= 3'd0;
            version_reg      <= 16'd0;
            blocks_left_reg  <= 16'd0;
            current_tag_reg  <= 16'd0;
            bytes_left_reg   <= 32'd0;
            current_kind_reg <= 4'd0;
            final_status_reg <= 3'd0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_version_reg <= cfg_wr_data;
            end
            if (in_xfer) begin
                phase_reg        <= phase_next;
                fbi_reg          <= fbi_next;
                version_reg      <= version_next;
                blocks_left_reg  <= blocks_left_next;
                current_tag_reg  <= current_tag_next;
                bytes_left_reg   <= bytes_left_next;
                current_kind_reg <= current_kind_next;
                final_status_reg <= final_status_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= m_tlast_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_last_needs_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tuser_reg[0])
        else $error("block_last set on a result without payload");

    a_empty_output_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled while result register is empty");

    a_data_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != 32'd0)
        else $error("payload phase entered with zero bytes left");

    a_done_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> final_status_reg != ST_PARSING)
        else $error("finished parser holds no final status");

    a_final_byte_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && !s_tuser && phase_reg == PH_DATA && bytes_left_reg == 32'd1 &&
        current_kind_reg < KIND_SKIP |=> m_tvalid_reg && m_tlast_reg)
        else $error("final payload byte of a block not marked");

endmodule
